// File: hdl/sbf_pkg.sv
// sbf_pkg: constants, types and state codes for the store buffer with load forwarding.
// Used by sbf_line_ram and store_buffer_load_forward_unit; depends on nothing.
`timescale 1ns / 1ps

package sbf_pkg;

  // buffer geometry (LINE_BYTES a power of two, 8..64; ENTRIES 1..16)
  localparam int ENTRIES    = 16;
  localparam int LINE_BYTES = 64;
  localparam int WORD_BYTES = 8;
  localparam int WORDS      = LINE_BYTES / WORD_BYTES;
  localparam int MAX_LEN    = 8;

  // word field widths
  localparam int ADDR_W   = 56;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int IDX_IN_W = 4;
  localparam int BV_W     = 8;

  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int LINE_W    = ADDR_W - OFF_W;
  localparam int EIDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MEM_DEPTH = ENTRIES * WORDS;
  localparam int MA_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LBX_W     = LINE_BYTES + WORD_BYTES;

  // input tdata layout
  localparam int LEN_LSB    = ADDR_W;
  localparam int DATA_LSB   = LEN_LSB + LEN_W;
  localparam int IDX_LSB    = DATA_LSB + DATA_W;
  localparam int IN_TDATA_W = 128;

  // output tdata layout
  localparam int BV_LSB      = 1;
  localparam int LD_LSB      = BV_LSB + BV_W;
  localparam int OUT_USED_W  = LD_LSB + DATA_W;
  localparam int OUT_TDATA_W = 80;

  // request kinds (in_tuser)
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE2,
    S_SCAN,
    S_LAST,
    S_DONE
  } sbf_state_t;

  // line RAM write port
  typedef struct packed {
    logic                    we;
    logic [MA_W-1:0]         addr;
    logic [WORD_BYTES-1:0]   be;
    logic [DATA_W-1:0]       data;
  } sbf_wr_t;

endpackage

// File: hdl/store_buffer_load_forward_unit.sv
// store_buffer_load_forward_unit: store-to-load forwarding buffer; uses sbf_pkg, sbf_line_ram.
// Store: the low line word is written on accept, the high word in S_STORE2 when the bytes span
// two line words. Load: S_SCAN reads every entry from the line RAM, one entry per cycle, then
// S_LAST does the last merge and S_DONE loads the output; with no entry busy the load goes
// straight to S_DONE. No new request is taken before the result is loaded; a held result stalls the next load.
// Reset (rst_n low, synchronous): all entries free, masks and addresses cleared, output empty.
`timescale 1ns / 1ps

module store_buffer_load_forward_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // request word
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, lowest bit up: phys_addr[56], access_len[4], store_data[64], entry_index[4]
  input  logic [sbf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: req_type (0 load, 1 store)
  input  logic                               in_tuser,
  // result word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, lowest bit up: hit[1], byte_valid[8], load_data[64], zero pad[7]
  output logic [sbf_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import sbf_pkg::*;

  // ---------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------
  logic                  in_fire;
  logic                  is_store;
  logic [ADDR_W-1:0]     in_addr;
  logic [LEN_W-1:0]      in_len;
  logic [LEN_W-1:0]      in_len_c;
  logic [DATA_W-1:0]     in_data;
  logic [IDX_IN_W-1:0]   in_idx_raw;
  logic [EIDX_W-1:0]     in_idx;
  logic [BV_W-1:0]       in_lm;        // byte lanes of the access, from length
  logic [OFF_W-1:0]      in_off;
  logic [2:0]            in_o3;
  logic [OFF_W-1:0]      in_w0;
  logic [LINE_W-1:0]     in_line;
  logic                  st_ok;        // entry index in range
  logic [2*DATA_W-1:0]   st_sd;        // store bytes aligned to word pair
  logic [2*WORD_BYTES-1:0] st_be;
  logic [LINE_BYTES-1:0] st_nm;        // new mask bits, line end dropped
  logic                  st_hi_ok;     // second word needed and inside the line
  logic [MA_W-1:0]       st_waddr;

  assign in_addr    = in_tdata[ADDR_W-1:0];
  assign in_len     = in_tdata[LEN_LSB +: LEN_W];
  assign in_data    = in_tdata[DATA_LSB +: DATA_W];
  assign in_idx_raw = in_tdata[IDX_LSB +: IDX_IN_W];
  assign in_idx     = EIDX_W'(in_idx_raw);
  assign is_store   = (in_tuser == REQ_STORE);

  assign in_len_c = (32'(in_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : in_len;
  assign in_lm    = BV_W'((16'd1 << in_len_c) - 16'd1);
  assign in_off   = in_addr[OFF_W-1:0];
  assign in_o3    = in_off[2:0];
  assign in_w0    = in_off >> 3;
  assign in_line  = in_addr[ADDR_W-1:OFF_W];

  assign st_ok    = 32'(in_idx_raw) < ENTRIES;
  assign st_sd    = (2*DATA_W)'(in_data) << {in_o3, 3'b000};
  assign st_be    = (2*WORD_BYTES)'(in_lm) << in_o3;
  assign st_nm    = LINE_BYTES'(LBX_W'(in_lm) << in_off);
  assign st_hi_ok = (st_be[2*WORD_BYTES-1:WORD_BYTES] != '0) &&
                    (32'(in_w0) + 32'd1 < WORDS);
  assign st_waddr = MA_W'(32'(in_idx) * WORDS + 32'(in_w0));

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  sbf_state_t            state_r, state_nxt;
  logic [ENTRIES-1:0]    busy_r;
  logic [LINE_BYTES-1:0] entry_mask_r [ENTRIES];
  logic [LINE_W-1:0]     entry_line_r [ENTRIES];   // line part of entry address

  logic [EIDX_W-1:0]     cnt_r;        // entry being read during the scan
  logic                  rd_vld_r;     // RAM output holds a scanned entry
  logic [BV_W-1:0]       hb_r;         // lanes that entry forwards

  // load under way
  logic [LINE_W-1:0]     ld_line_r;
  logic [OFF_W-1:0]      ld_off_r;
  logic [BV_W-1:0]       ld_lm_r;
  logic [BV_W-1:0]       acc_valid_r;
  logic [DATA_W-1:0]     acc_data_r;

  // second half of a spanning store
  logic [MA_W-1:0]       hi_addr_r;
  logic [WORD_BYTES-1:0] hi_be_r;
  logic [DATA_W-1:0]     hi_data_r;

  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // ---------------------------------------------------------------
  // Entry table read (one address: scan entry in S_SCAN, store entry otherwise)
  // ---------------------------------------------------------------
  logic [EIDX_W-1:0]     arr_idx;
  logic [LINE_BYTES-1:0] m_rd;
  logic [LINE_W-1:0]     l_rd;
  logic                  match;
  logic [BV_W-1:0]       hb_nxt;
  logic [OFF_W-1:0]      ld_w0;
  logic [OFF_W-1:0]      ld_w1;

  assign arr_idx = (state_r == S_SCAN) ? cnt_r : in_idx;
  assign m_rd    = entry_mask_r[arr_idx];
  assign l_rd    = entry_line_r[arr_idx];
  assign match   = (m_rd != '0) && (l_rd == ld_line_r);
  // mask bits past the line end shift in as zero, so such lanes never forward
  assign hb_nxt  = match ? (BV_W'(m_rd >> ld_off_r) & ld_lm_r) : '0;

  assign ld_w0 = ld_off_r >> 3;
  assign ld_w1 = (32'(ld_w0) + 32'd1 < WORDS) ? (ld_w0 + OFF_W'(1)) : ld_w0;

  // ---------------------------------------------------------------
  // Line RAM
  // ---------------------------------------------------------------
  sbf_wr_t               ram_wr;
  logic [MA_W-1:0]       ram_ra;
  logic [MA_W-1:0]       ram_rb;
  logic [DATA_W-1:0]     ram_da;
  logic [DATA_W-1:0]     ram_db;

  assign ram_ra = MA_W'(32'(cnt_r) * WORDS + 32'(ld_w0));
  assign ram_rb = MA_W'(32'(cnt_r) * WORDS + 32'(ld_w1));

  sbf_line_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (ram_da),
    .rdata_b (ram_db)
  );

  // byte k of the load sits at byte (offset mod 8) + k of the word pair
  logic [2*DATA_W-1:0]   sel_pair;
  assign sel_pair = {ram_db, ram_da} >> {ld_off_r[2:0], 3'b000};

  // ---------------------------------------------------------------
  // Control: next state
  // ---------------------------------------------------------------
  logic out_load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_store) begin
            state_nxt = (st_ok && st_hi_ok) ? S_STORE2 : S_IDLE;
          end else begin
            state_nxt = (busy_r != '0) ? S_SCAN : S_DONE;
          end
        end
      end
      S_STORE2: state_nxt = S_IDLE;
      S_SCAN: begin
        if (cnt_r == EIDX_W'(ENTRIES - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Control: outputs
  // ---------------------------------------------------------------
  always_comb begin
    in_tready   = 1'b0;
    out_load    = 1'b0;
    ram_wr.we   = 1'b0;
    ram_wr.addr = st_waddr;
    ram_wr.be   = st_be[WORD_BYTES-1:0];
    ram_wr.data = st_sd[DATA_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_wr.we = in_tvalid && is_store && st_ok;
      end
      S_STORE2: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = hi_addr_r;
        ram_wr.be   = hi_be_r;
        ram_wr.data = hi_data_r;
      end
      S_DONE:   out_load = !out_tvalid_r || out_tready;
      default: begin
      end
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_mask_r[i] <= '0;
        entry_line_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);

      if (in_fire && is_store && st_ok) begin
        entry_mask_r[in_idx] <= m_rd | st_nm;
        entry_line_r[in_idx] <= in_line;
        busy_r[in_idx]       <= 1'b1;
      end

      if (in_fire && !is_store) begin
        cnt_r <= '0;
      end else if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + EIDX_W'(1);
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && is_store) begin
      hi_addr_r <= st_waddr + MA_W'(1);
      hi_be_r   <= st_be[2*WORD_BYTES-1:WORD_BYTES];
      hi_data_r <= st_sd[2*DATA_W-1:DATA_W];
    end

    if (in_fire && !is_store) begin
      ld_line_r   <= in_line;
      ld_off_r    <= in_off;
      ld_lm_r     <= in_lm;
      acc_valid_r <= '0;
      acc_data_r  <= '0;
    end else if (rd_vld_r) begin
      // later entries overwrite earlier ones lane by lane
      for (int k = 0; k < BV_W; k++) begin
        if (hb_r[k]) begin
          acc_data_r[8*k +: 8] <= sel_pair[8*k +: 8];
          acc_valid_r[k]       <= 1'b1;
        end
      end
    end

    hb_r <= hb_nxt;

    if (out_load) begin
      out_data_r <= {(OUT_TDATA_W - OUT_USED_W)'(0), acc_data_r, acc_valid_r,
                     (acc_valid_r != '0)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // load with no busy entry goes straight to the result with nothing forwarded
  a_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_store && (busy_r == '0)) |=>
      (state_r == S_DONE) && (acc_valid_r == '0))
    else $error("empty-buffer load did not bypass the scan");

  // every scan cycle is followed by a merge of that entry
  a_scan_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> rd_vld_r)
    else $error("scanned entry not merged");

  // forwarded lanes stay inside the requested length
  a_lanes_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ((acc_valid_r & ~ld_lm_r) == '0))
    else $error("forwarded lane outside the access");

  // out-of-range store leaves the busy bits untouched
  a_bad_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_store && !st_ok) |=> $stable(busy_r))
    else $error("out-of-range store changed busy bits");
`endif

endmodule

// File: hdl/sbf_line_ram.sv
// sbf_line_ram: line data store, one byte-enabled write port, two registered read ports.
// Depends on sbf_pkg for geometry and the write port struct.
`timescale 1ns / 1ps

module sbf_line_ram (
  input  logic                           clk,
  input  sbf_pkg::sbf_wr_t               wr,
  input  logic [sbf_pkg::MA_W-1:0]       raddr_a,
  input  logic [sbf_pkg::MA_W-1:0]       raddr_b,
  output logic [sbf_pkg::DATA_W-1:0]     rdata_a,
  output logic [sbf_pkg::DATA_W-1:0]     rdata_b
);
  import sbf_pkg::*;

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      for (int b = 0; b < WORD_BYTES; b++) begin
        if (wr.be[b]) begin
          mem[wr.addr][8*b +: 8] <= wr.data[8*b +: 8];
        end
      end
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: test/tb_store_buffer_load_forward_unit.sv
// tb_store_buffer_load_forward_unit: self-checking bench for the store buffer with forwarding.
// Directed and random store/load words go in; a local model of the entry array predicts each load.
// Depends on sbf_pkg and store_buffer_load_forward_unit only.
`timescale 1ns / 1ps

module tb_store_buffer_load_forward_unit;
  import sbf_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;       // cycles with no word moving on either side
  localparam int END_SETTLE      = ENTRIES + 8; // quiet time after the last load result
  localparam int HOLD_CYCLES     = 300;        // long sink stall for the pressure test
  localparam int RANDOM_WORDS    = 460;
  localparam int POOL_LINES      = 6;

  // one load result as the block packs it
  typedef struct packed {
    logic              hit;
    logic [BV_W-1:0]   byte_valid;
    logic [DATA_W-1:0] load_data;
  } fwd_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // lowest bit up: phys_addr[56], access_len[4], store_data[64], entry_index[4]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // req_type: REQ_LOAD or REQ_STORE
  logic                   in_tuser = REQ_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // lowest bit up: hit[1], byte_valid[8], load_data[64], zero pad[7]
  logic [OUT_TDATA_W-1:0] out_tdata;

  store_buffer_load_forward_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the store buffer, updated in accept order.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]     shadow_addr [ENTRIES];
  logic [7:0]            shadow_line [ENTRIES][LINE_BYTES];
  logic [LINE_BYTES-1:0] shadow_mask [ENTRIES];
  logic [ENTRIES-1:0]    shadow_busy;

  fwd_result_t pending_loads[$];   // predicted results not yet seen at the output

  int err_count     = 0;
  int loads_checked = 0;
  int stores_sent   = 0;
  int hits_seen     = 0;

  bit sender_steady = 1'b0;  // no input gaps while set
  bit sink_steady   = 1'b0;  // out_tready held high while set
  int sink_hold     = 0;     // cycles of forced out_tready low, counted by the sink

  function automatic int eff_len(input logic [LEN_W-1:0] len);
    // lengths above eight saturate
    return (len > MAX_LEN) ? MAX_LEN : int'(len);
  endfunction

  function automatic void commit_store(input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len,
                                       input logic [DATA_W-1:0] data,
                                       input logic [IDX_IN_W-1:0] idx);
    int off;
    int pos;
    int n;
    off = int'(addr % LINE_BYTES);
    n   = eff_len(len);
    if (int'(idx) >= ENTRIES) return;   // out-of-range entry: no effect
    for (int k = 0; k < n; k++) begin
      pos = off + k;
      if (pos >= LINE_BYTES) break;     // bytes past the line end are dropped
      shadow_line[idx][pos] = data[8*k +: 8];
      shadow_mask[idx][pos] = 1'b1;
    end
    shadow_addr[idx] = addr;            // address replaced even for a zero length
    shadow_busy[idx] = 1'b1;
  endfunction

  function automatic fwd_result_t forward_lookup(input logic [ADDR_W-1:0] addr,
                                                 input logic [LEN_W-1:0] len);
    fwd_result_t r;
    int off;
    int pos;
    int n;
    r   = '0;
    off = int'(addr % LINE_BYTES);
    n   = eff_len(len);
    if (shadow_busy != '0) begin
      // ascending scan: the highest matching entry overwrites earlier bytes
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_mask[i] == '0) continue;
        if ((shadow_addr[i] / LINE_BYTES) != (addr / LINE_BYTES)) continue;
        for (int k = 0; k < n; k++) begin
          pos = off + k;
          if (pos >= LINE_BYTES) break;
          if (shadow_mask[i][pos]) begin
            r.load_data[8*k +: 8] = shadow_line[i][pos];
            r.byte_valid[k]       = 1'b1;
          end
        end
      end
    end
    r.hit = (r.byte_valid != '0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word per call, driven at negedge, accepted at posedge.
  // tvalid stays high on return so back-to-back words need no re-raise.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data,
                           input logic [IDX_IN_W-1:0] idx);
    if (!sender_steady && $urandom_range(0, 99) < 9) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = {idx, data, len, addr};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_STORE) begin
      commit_store(addr, len, data, idx);
      stores_sent++;
    end else begin
      pending_loads.push_back(forward_lookup(addr, len));
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sink: random ready, steady stretches, and a counted hold-off.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready = 1'b0;
      sink_hold  = sink_hold - 1;
    end else if (sink_steady) begin
      out_tready = 1'b1;
    end else begin
      out_tready = ($urandom_range(0, 99) >= 9);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fwd_result_t want;
    fwd_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit        = out_tdata[0];
      got.byte_valid = out_tdata[BV_LSB +: BV_W];
      got.load_data  = out_tdata[LD_LSB +: DATA_W];
      if (pending_loads.size() == 0) begin
        $display("%0t: unexpected result word, got hit=%0b bv=%02h data=%016h",
                 $time, got.hit, got.byte_valid, got.load_data);
        err_count++;
      end else begin
        want = pending_loads.pop_front();
        loads_checked++;
        if (got.hit) hits_seen++;
        if (got.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, got.hit);
          err_count++;
        end
        if (got.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid mismatch, expected %02h actual %02h",
                   $time, want.byte_valid, got.byte_valid);
          err_count++;
        end
        if (got.load_data !== want.load_data) begin
          $display("%0t: load_data mismatch, expected %016h actual %016h",
                   $time, want.load_data, got.load_data);
          err_count++;
        end
      end
    end
  end

  // watchdog: stop a hung run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no word moved for %0d cycles, %0d results pending",
                 $time, WATCHDOG_CYCLES, pending_loads.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // mostly 1..8, some zero and some oversize lengths
  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return LEN_W'($urandom_range(MAX_LEN + 1, 15));
    return LEN_W'($urandom_range(1, MAX_LEN));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // nothing busy yet: every lookup must come back empty
  task automatic test_empty_buffer();
    send_word(REQ_LOAD, '0, 4'd8, '0, '0);
    send_word(REQ_LOAD, '1, 4'd15, '1, '1);
    send_word(REQ_LOAD, 56'h40, 4'd0, '0, '0);
    in_tvalid = 1'b0;
  endtask

  // full, partial and overlapping forwarding; priority of higher entries
  task automatic test_forwarding();
    send_word(REQ_STORE, 56'h1000, 4'd8, 64'h1122_3344_5566_7788, 4'd0);
    send_word(REQ_LOAD,  56'h1000, 4'd8, '0, '0);
    send_word(REQ_LOAD,  56'h1004, 4'd4, '0, '0);
    send_word(REQ_LOAD,  56'h1006, 4'd8, '0, '0);
    send_word(REQ_STORE, 56'h1002, 4'd2, 64'h0000_0000_0000_aabb, 4'd5);
    send_word(REQ_LOAD,  56'h1000, 4'd8, '0, '0);
    // rewrite a busy entry: same line, new address, mask grows
    send_word(REQ_STORE, 56'h1020, 4'd4, 64'h0000_0000_dead_beef, 4'd0);
    send_word(REQ_LOAD,  56'h1020, 4'd8, '0, '0);
    send_word(REQ_LOAD,  56'h1000, 4'd8, '0, '0);
    // busy buffer, different line
    send_word(REQ_LOAD,  56'h2000, 4'd8, '0, '0);
    in_tvalid = 1'b0;
  endtask

  // zero length, saturated length, accesses running past the line end
  task automatic test_length_cases();
    send_word(REQ_STORE, 56'h3000, 4'd0, '1, 4'd15);
    send_word(REQ_LOAD,  56'h3000, 4'd8, '0, '0);
    send_word(REQ_STORE, 56'h3008, 4'd12, '1, 4'd15);
    send_word(REQ_LOAD,  56'h3008, 4'd15, '0, '0);
    send_word(REQ_STORE, 56'h303c, 4'd8, 64'h0102_0304_0506_0708, 4'd3);
    send_word(REQ_LOAD,  56'h303a, 4'd8, '0, '0);
    send_word(REQ_LOAD,  56'h303c, 4'd0, '0, '0);
    in_tvalid = 1'b0;
  endtask

  // top and bottom of the address space
  task automatic test_address_extremes();
    send_word(REQ_STORE, '1, 4'd1, '1, 4'd7);
    send_word(REQ_LOAD,  '1, 4'd8, '0, '0);
    send_word(REQ_LOAD,  {{LINE_W{1'b1}}, {OFF_W{1'b0}}}, 4'd8, '0, '0);
    send_word(REQ_STORE, '0, 4'd8, '0, 4'd8);
    send_word(REQ_LOAD,  '0, 4'd8, '0, '0);
    in_tvalid = 1'b0;
  endtask

  // mostly stores and loads on a few hot lines, so entries collide and forward;
  // the rest are wild addresses. First part runs without any idling.
  task automatic test_random_traffic();
    logic [LINE_W-1:0] pool [POOL_LINES];
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              kind;
    pool[0] = '0;
    pool[1] = '1;
    for (int p = 2; p < POOL_LINES; p++) pool[p] = LINE_W'(rand_addr());
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sender_steady = (n < 120);
      sink_steady   = (n < 120);
      len  = rand_len();
      off  = OFF_W'($urandom_range(0, LINE_BYTES - 1));
      if ($urandom_range(0, 1)) off[2:0] = '0;      // half of them aligned
      if ($urandom_range(0, 99) < 80) addr = {pool[$urandom_range(0, POOL_LINES - 1)], off};
      else addr = rand_addr();
      kind = ($urandom_range(0, 99) < 45) ? REQ_STORE : REQ_LOAD;
      send_word(kind, addr, len, rand_data(), IDX_IN_W'($urandom_range(0, 15)));
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    in_tvalid = 1'b0;
  endtask

  // sink stalls for a long stretch while loads keep coming: input must back up
  task automatic test_backpressure();
    sink_hold = HOLD_CYCLES;
    for (int n = 0; n < 16; n++)
      send_word(REQ_LOAD, (n % 2) ? 56'h1000 : rand_addr(), 4'd8, '0, '0);
    in_tvalid = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_addr[i] = '0;
      shadow_mask[i] = '0;
      for (int b = 0; b < LINE_BYTES; b++) shadow_line[i][b] = '0;
    end
    shadow_busy = '0;

    // single synchronous reset at the start
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_buffer();
    test_forwarding();
    test_length_cases();
    test_address_extremes();
    test_random_traffic();
    test_backpressure();

    // drain, then give the block time to show any stray result
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    $display("Covered: %0d stores, %0d load results (%0d with forwarded bytes),",
             stores_sent, loads_checked, hits_seen);
    $display("incl. zero/oversize lengths, line-end crossing, entry priority, sink stall.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
